### design/lz_rle_byte_decompressor_macros.svh
// Assertion macros for the LZ/RLE byte decompressor.
// No dependencies; included by the top-level module.
`ifndef LZ_RLE_BYTE_DECOMPRESSOR_MACROS_SVH
`define LZ_RLE_BYTE_DECOMPRESSOR_MACROS_SVH

// Checked on every edge out of reset.
`define LZR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define LZR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/lzr_pkg.sv
// Shared types and constants of the LZ/RLE byte decompressor.
// No dependencies.
package lzr_pkg;

  // History window; the depth is a power of two so addresses wrap naturally.
  localparam int unsigned HIST_DEPTH = 4096;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);

  // Output queue depth.
  localparam int unsigned OQ_DEPTH = 3;

  // Header commands (top three bits); the remaining codes are bad commands.
  localparam logic [2:0] CMD_LIT    = 3'd0;
  localparam logic [2:0] CMD_ZERO   = 3'd1;
  localparam logic [2:0] CMD_REPEAT = 3'd2;
  localparam logic [2:0] CMD_COPY8  = 3'd3;
  localparam logic [2:0] CMD_COPY16 = 3'd4;
  localparam logic [2:0] CMD_LITZ   = 3'd5;

  localparam logic [7:0] END_MARKER = 8'hFF;
  localparam logic [4:0] CNT_MASK   = 5'h1F;

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_END     = 2'd1,
    ST_BAD     = 2'd2,
    ST_REFUSED = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_CNT_LO  = 7'b0000010,
    PH_CNT_HI  = 7'b0000100,
    PH_OPD_LO  = 7'b0001000,
    PH_OPD_HI  = 7'b0010000,
    PH_LITERAL = 7'b0100000,
    PH_RUN     = 7'b1000000
  } phase_e;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       pending;
  } res_t;

  // Write/result stage after the decode.
  typedef struct packed {
    logic               mem;   // byte comes from the history read
    logic               fwd;   // read hit the write of the previous beat
    logic               wr;    // byte goes into the history
    logic [HIST_AW-1:0] addr;  // history write address
    res_t               res;
  } s1_t;

endpackage

### design/lz_rle_byte_decompressor.sv
// LZ/RLE byte decompressor: one input beat per cycle while the output queue has room;
// results pass the stage 1 register and the output queue. Throughput is set by the
// single history read and write per beat; a back offset of one is served by forwarding
// the byte written in the cycle before. After reset the 4096-entry history is cleared,
// with input held off. Async active-low reset. Depends on lzr_pkg and assertion macros.
`include "lz_rle_byte_decompressor_macros.svh"

module lz_rle_byte_decompressor import lzr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       run_pending_o
);

  // Decoder state
  logic [HIST_AW-1:0] wp_q, wp_d;
  phase_e             phase_q, phase_d;
  logic [2:0]         cmd_q, cmd_d;
  logic [15:0]        rem_q, rem_d;
  logic [7:0]         len_lo_q, len_lo_d;
  logic [15:0]        opd_q, opd_d;
  logic               zero_due_q, zero_due_d;

  // Clearing pass
  logic               clr_active_q;
  logic [HIST_AW-1:0] clr_addr_q;

  // Stage 1 and output queue
  logic               s1_v_q;
  s1_t                s1_q, s1_d;
  logic [7:0]         prev_byte_q;
  logic [7:0]         s1_byte;
  res_t               oq_mem [OQ_DEPTH];
  logic [1:0]         oq_wp_q, oq_rp_q, oq_cnt_q;

  // History memory
  logic [7:0]         hist_mem [HIST_DEPTH];
  logic [7:0]         rdata_q;
  logic               mem_re;
  logic [HIST_AW-1:0] mem_raddr;
  logic               mem_we;
  logic [HIST_AW-1:0] mem_waddr;
  logic [7:0]         mem_wdata;

  // Decode helpers
  logic               in_acc, out_acc, pend;
  logic               res_v;
  logic               kc_go;
  logic [2:0]         kc_cmd;
  logic [15:0]        kc_cnt;
  logic [15:0]        rem_dec;
  logic [HIST_AW-1:0] wp_inc;
  logic [2:0]         occ;

  assign occ        = {1'b0, oq_cnt_q} + {2'b0, s1_v_q};
  assign in_ready_o = !clr_active_q && (occ < 3'(OQ_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;

  assign pend    = (phase_q == PH_RUN) || zero_due_q;
  assign rem_dec = rem_q - 16'd1;
  assign wp_inc  = wp_q + {{(HIST_AW-1){1'b0}}, 1'b1};

  // Decode one beat: next state, result and history access
  always_comb begin
    wp_d       = wp_q;
    phase_d    = phase_q;
    cmd_d      = cmd_q;
    rem_d      = rem_q;
    len_lo_d   = len_lo_q;
    opd_d      = opd_q;
    zero_due_d = zero_due_q;
    res_v      = 1'b0;
    s1_d       = '0;
    s1_d.res.status = ST_DATA;
    kc_go      = 1'b0;
    kc_cmd     = cmd_q;
    kc_cnt     = rem_q;
    mem_re     = 1'b0;
    mem_raddr  = wp_inc - opd_q[HIST_AW-1:0];

    if (in_acc) begin
      if (action_i) begin
        // drain one run byte
        if (zero_due_q) begin
          s1_d.wr    = 1'b1;
          zero_due_d = 1'b0;
          rem_d      = rem_dec;
          phase_d    = (rem_dec != 16'd0) ? PH_LITERAL : PH_HEADER;
          res_v      = 1'b1;
        end else if (phase_q == PH_RUN) begin
          s1_d.wr = 1'b1;
          if (cmd_q == CMD_REPEAT) begin
            s1_d.res.data = opd_q[7:0];
          end else if (cmd_q inside {CMD_COPY8, CMD_COPY16}) begin
            s1_d.mem = 1'b1;
            mem_re   = 1'b1;
          end
          rem_d = rem_dec;
          if (rem_dec == 16'd0) begin
            phase_d = PH_HEADER;
          end
          res_v = 1'b1;
        end
      end else if (pend) begin
        s1_d.res.status = ST_REFUSED;
        res_v           = 1'b1;
      end else begin
        case (phase_q)
          PH_CNT_LO: begin
            len_lo_d = in_byte_i;
            phase_d  = PH_CNT_HI;
          end
          PH_CNT_HI: begin
            kc_go  = 1'b1;
            kc_cnt = {in_byte_i, len_lo_q};
          end
          PH_OPD_LO: begin
            opd_d = {8'h00, in_byte_i};
            if (cmd_q == CMD_COPY16) begin
              phase_d = PH_OPD_HI;
            end else begin
              phase_d = (rem_q != 16'd0) ? PH_RUN : PH_HEADER;
            end
          end
          PH_OPD_HI: begin
            opd_d   = {in_byte_i, opd_q[7:0]};
            phase_d = (rem_q != 16'd0) ? PH_RUN : PH_HEADER;
          end
          PH_LITERAL: begin
            s1_d.wr       = 1'b1;
            s1_d.res.data = in_byte_i;
            if (cmd_q == CMD_LITZ) begin
              zero_due_d = 1'b1;
            end else begin
              rem_d = rem_dec;
              if (rem_dec == 16'd0) begin
                phase_d = PH_HEADER;
              end
            end
            res_v = 1'b1;
          end
          default: begin
            // header byte
            if (in_byte_i == END_MARKER) begin
              phase_d         = PH_HEADER;
              rem_d           = 16'd0;
              wp_d            = '0;
              s1_d.res.status = ST_END;
              res_v           = 1'b1;
            end else begin
              cmd_d = in_byte_i[7:5];
              rem_d = {11'd0, in_byte_i[4:0] & CNT_MASK};
              if (in_byte_i[4:0] == 5'd0) begin
                phase_d = PH_CNT_LO;
              end else begin
                kc_go  = 1'b1;
                kc_cmd = in_byte_i[7:5];
                kc_cnt = {11'd0, in_byte_i[4:0]};
              end
            end
          end
        endcase

        // count known: pick what follows
        if (kc_go) begin
          rem_d = kc_cnt;
          case (kc_cmd)
            CMD_LIT, CMD_LITZ: begin
              phase_d = (kc_cnt != 16'd0) ? PH_LITERAL : PH_HEADER;
            end
            CMD_ZERO: begin
              phase_d = (kc_cnt != 16'd0) ? PH_RUN : PH_HEADER;
            end
            CMD_REPEAT, CMD_COPY8, CMD_COPY16: begin
              opd_d   = 16'd0;
              phase_d = PH_OPD_LO;
            end
            default: begin
              phase_d         = PH_HEADER;
              rem_d           = 16'd0;
              wp_d            = '0;
              s1_d.res.status = ST_BAD;
              res_v           = 1'b1;
            end
          endcase
        end
      end

      // history write slot and forwarding for a read of the entry written now
      if (s1_d.wr) begin
        wp_d = wp_inc;
      end
      s1_d.addr        = wp_inc;
      s1_d.fwd         = s1_d.mem && s1_v_q && s1_q.wr && (mem_raddr == s1_q.addr);
      s1_d.res.pending = (phase_d == PH_RUN) || zero_due_d;
    end
  end

  // Decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      phase_q    <= PH_HEADER;
      cmd_q      <= 3'd0;
      rem_q      <= 16'd0;
      len_lo_q   <= 8'd0;
      opd_q      <= 16'd0;
      zero_due_q <= 1'b0;
    end else begin
      wp_q       <= wp_d;
      phase_q    <= phase_d;
      cmd_q      <= cmd_d;
      rem_q      <= rem_d;
      len_lo_q   <= len_lo_d;
      opd_q      <= opd_d;
      zero_due_q <= zero_due_d;
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + {{(HIST_AW-1){1'b0}}, 1'b1};
      if (clr_addr_q == HIST_AW'(HIST_DEPTH - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // Stage 1: resolve the byte, with forwarding from the previous write
  assign s1_byte = s1_q.mem ? (s1_q.fwd ? prev_byte_q : rdata_q) : s1_q.res.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_acc && res_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_v_q) begin
      prev_byte_q <= s1_byte;
    end
  end

  // History memory: one write port, one registered read port
  assign mem_we    = clr_active_q || (s1_v_q && s1_q.wr);
  assign mem_waddr = clr_active_q ? clr_addr_q : s1_q.addr;
  assign mem_wdata = clr_active_q ? 8'h00 : s1_byte;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= hist_mem[mem_raddr];
    end
  end

  // Output queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= 2'd0;
      oq_rp_q  <= 2'd0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (s1_v_q) begin
        oq_wp_q <= (oq_wp_q == 2'(OQ_DEPTH - 1)) ? 2'd0 : oq_wp_q + 2'd1;
      end
      if (out_acc) begin
        oq_rp_q <= (oq_rp_q == 2'(OQ_DEPTH - 1)) ? 2'd0 : oq_rp_q + 2'd1;
      end
      oq_cnt_q <= oq_cnt_q + {1'b0, s1_v_q} - {1'b0, out_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      oq_mem[oq_wp_q] <= '{data: s1_byte, status: s1_q.res.status,
                           pending: s1_q.res.pending};
    end
  end

  assign out_valid_o   = (oq_cnt_q != 2'd0);
  assign out_byte_o    = oq_mem[oq_rp_q].data;
  assign status_o      = oq_mem[oq_rp_q].status;
  assign run_pending_o = oq_mem[oq_rp_q].pending;

  // Assertions
  `LZR_ASSERT_ALWAYS(a_no_accept_in_clear, clr_active_q |-> !in_ready_o,
    "input accepted while history is being cleared")
  `LZR_ASSERT(a_queue_bound, occ <= 3'(OQ_DEPTH),
    "output queue and stage 1 hold more beats than the queue depth")
  `LZR_ASSERT(a_no_write_in_clear, s1_v_q |-> !clr_active_q,
    "result write collides with the clearing pass")
  `LZR_ASSERT(a_fwd_only_copy, (s1_v_q && s1_q.fwd) |-> (s1_q.mem && $past(s1_v_q)),
    "forwarding flagged without a copy following a write")
  `LZR_ASSERT(a_refused_pending,
    (out_valid_o && status_o == ST_REFUSED) |-> run_pending_o,
    "byte refused while no run is pending")

endmodule

### dv/tb.sv
// Testbench for lz_rle_byte_decompressor: directed and random compressed streams,
// a class-based scoreboard that predicts each output beat, and random idling on both sides.
// Depends on lzr_pkg and the decompressor RTL.
`timescale 1ns / 1ps

import lzr_pkg::*;

// Tracks the decoder state and holds the output beats it predicts.
class decomp_scoreboard;
  logic [7:0]         hist [HIST_DEPTH];
  logic [HIST_AW-1:0] wptr;
  phase_e             phase;
  logic [2:0]         cmd;
  logic [15:0]        remaining;
  logic [7:0]         len_lo;
  logic [15:0]        operand;
  logic               zero_due;
  res_t               expected_out[$];
  int unsigned        errors;

  function new();
    foreach (hist[i]) hist[i] = 8'h00;
    wptr      = '0;
    phase     = PH_HEADER;
    cmd       = CMD_LIT;
    remaining = '0;
    len_lo    = '0;
    operand   = '0;
    zero_due  = 1'b0;
    errors    = 0;
  endfunction

  function bit busy();
    return (phase == PH_RUN) || zero_due;
  endfunction

  function int unsigned outstanding();
    return expected_out.size();
  endfunction

  function void put_byte(logic [7:0] v);
    wptr = wptr + 1'b1;
    hist[wptr] = v;
  endfunction

  // pending flag reflects the state after this beat
  function void push(logic [7:0] d, status_e s);
    res_t r;
    r.data    = d;
    r.status  = s;
    r.pending = busy();
    expected_out.push_back(r);
  endfunction

  // Count is in 'remaining'; choose what the command needs next.
  function void count_known();
    case (cmd)
      CMD_LIT, CMD_LITZ: phase = (remaining != 0) ? PH_LITERAL : PH_HEADER;
      CMD_ZERO:          phase = (remaining != 0) ? PH_RUN : PH_HEADER;
      CMD_REPEAT, CMD_COPY8, CMD_COPY16: begin
        operand = '0;
        phase   = PH_OPD_LO;
      end
      default: begin
        phase     = PH_HEADER;
        remaining = '0;
        wptr      = '0;
        push(8'h00, ST_BAD);
      end
    endcase
  endfunction

  // Accepted input beat; returns 0 only for a drain with nothing pending.
  function bit note_beat(logic act, logic [7:0] b);
    logic [7:0]         v;
    logic [HIST_AW-1:0] src;
    if (act) begin
      // zero after an interleaved literal
      if (zero_due) begin
        put_byte(8'h00);
        zero_due  = 1'b0;
        remaining = remaining - 16'd1;
        phase     = (remaining != 0) ? PH_LITERAL : PH_HEADER;
        push(8'h00, ST_DATA);
        return 1'b1;
      end
      if (phase != PH_RUN) return 1'b0;
      v = 8'h00;
      if (cmd == CMD_REPEAT) begin
        v = operand[7:0];
      end else if (cmd == CMD_COPY8 || cmd == CMD_COPY16) begin
        src = wptr + 1'b1 - operand[HIST_AW-1:0];
        v   = hist[src];
      end
      put_byte(v);
      remaining = remaining - 16'd1;
      if (remaining == 0) phase = PH_HEADER;
      push(v, ST_DATA);
      return 1'b1;
    end

    // data byte offered while a run is still pending
    if (busy()) begin
      push(8'h00, ST_REFUSED);
      return 1'b1;
    end

    case (phase)
      PH_CNT_LO: begin
        len_lo = b;
        phase  = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        remaining = {b, len_lo};
        count_known();
      end
      PH_OPD_LO: begin
        operand = {8'h00, b};
        if (cmd == CMD_COPY16) phase = PH_OPD_HI;
        else phase = (remaining != 0) ? PH_RUN : PH_HEADER;
      end
      PH_OPD_HI: begin
        operand = {b, operand[7:0]};
        phase   = (remaining != 0) ? PH_RUN : PH_HEADER;
      end
      PH_LITERAL: begin
        put_byte(b);
        if (cmd == CMD_LITZ) begin
          zero_due = 1'b1;
        end else begin
          remaining = remaining - 16'd1;
          if (remaining == 0) phase = PH_HEADER;
        end
        push(b, ST_DATA);
      end
      default: begin
        if (b == END_MARKER) begin
          phase     = PH_HEADER;
          remaining = '0;
          wptr      = '0;
          push(8'h00, ST_END);
        end else begin
          cmd       = b[7:5];
          remaining = {11'd0, b[4:0] & CNT_MASK};
          if (remaining == 0) phase = PH_CNT_LO;
          else count_known();
        end
      end
    endcase
    return 1'b1;
  endfunction

  // Output beat against the oldest prediction.
  function void check_beat(logic [7:0] d, logic [1:0] s, logic p);
    res_t e;
    if (expected_out.size() == 0) begin
      $display("%0t: unexpected beat: byte %02h status %0d pending %0b", $time, d, s, p);
      errors++;
      return;
    end
    e = expected_out.pop_front();
    if (e.status !== s) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, s);
      errors++;
    end
    if (e.data !== d) begin
      $display("%0t: out_byte expected %02h actual %02h", $time, e.data, d);
      errors++;
    end
    if (e.pending !== p) begin
      $display("%0t: run_pending expected %0b actual %0b", $time, e.pending, p);
      errors++;
    end
  endfunction
endclass

module tb;

  localparam logic [2:0]  CMD_BAD_LO   = 3'd6;
  localparam logic [2:0]  CMD_BAD_HI   = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 330;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned TAIL_CYCLES  = 10;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       action_i    = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [1:0] status_o;
  logic       run_pending_o;

  decomp_scoreboard sb;
  bit               quiet;     // no idling on either side
  bit               noisy;     // stray drains and refused bytes mixed in
  int unsigned      fed_items;
  int unsigned      cycle_cnt;

  lz_rle_byte_decompressor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .status_o     (status_o),
    .run_pending_o(run_pending_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly no gap, some short ones, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // One input beat; returns at the edge that accepts it, valid left high.
  task automatic send_beat(input logic act, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    if (sb.note_beat(act, b)) fed_items++;
  endtask

  task automatic drain_beat();
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    send_beat(1'b1, junk);
  endtask

  // Drain the pending run, with the odd refused byte when noisy.
  task automatic settle();
    logic [7:0] junk;
    while (sb.busy()) begin
      if (noisy && $urandom_range(0, 24) == 0) begin
        junk = 8'($urandom_range(0, 255));
        send_beat(1'b0, junk);
      end else begin
        drain_beat();
      end
    end
  endtask

  task automatic feed(input logic [7:0] b);
    settle();
    if (noisy && $urandom_range(0, 29) == 0) drain_beat();
    send_beat(1'b0, b);
  endtask

  // Complete command: header, optional 16-bit count, operands, literals, then its run.
  task automatic emit_cmd(input logic [2:0] c, input int unsigned cnt, input bit ext,
                          input logic [15:0] opnd);
    logic [15:0] c16;
    logic [7:0]  lit;
    c16 = cnt[15:0];
    if (ext || c16 == 0 || c16 > CNT_MASK) begin
      feed({c, 5'd0});
      feed(c16[7:0]);
      feed(c16[15:8]);
    end else begin
      feed({c, c16[4:0]});
    end
    case (c)
      CMD_LIT, CMD_LITZ: begin
        repeat (c16) begin
          lit = 8'($urandom_range(0, 255));
          feed(lit);
        end
      end
      CMD_REPEAT, CMD_COPY8: feed(opnd[7:0]);
      CMD_COPY16: begin
        feed(opnd[7:0]);
        feed(opnd[15:8]);
      end
      default: ;
    endcase
    settle();
  endtask

  // Junk byte; a high count byte stays small so runs stay short.
  function automatic logic [7:0] noise_byte();
    logic [7:0] v;
    if (sb.phase == PH_CNT_HI) v = 8'($urandom_range(0, 1));
    else v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  // Walk the decoder back to a header boundary with harmless bytes.
  task automatic resync();
    logic [7:0] v;
    while (sb.phase != PH_HEADER || sb.busy()) begin
      if (sb.busy()) begin
        drain_beat();
      end else begin
        case (sb.phase)
          PH_CNT_LO: v = 8'($urandom_range(0, 40));
          PH_CNT_HI: v = 8'h00;
          default:   v = 8'($urandom_range(0, 255));
        endcase
        send_beat(1'b0, v);
      end
    end
  endtask

  task automatic broken_seq();
    int unsigned n;
    n = $urandom_range(1, 3);
    repeat (n) feed(noise_byte());
    resync();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Output side: random stalls, none while quiet.
  initial begin
    int unsigned gap;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      gap = pick_gap();
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i)
      sb.check_beat(out_byte_o, status_o, run_pending_o);
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, sb.outstanding());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int unsigned base;
    int unsigned r;
    int unsigned cnt;
    bit          ext;
    logic [2:0]  c;
    logic [15:0] opnd;
    sb    = new();
    quiet = 1'b0;
    noisy = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every command, zero counts, bad headers, end marker.
    emit_cmd(CMD_LIT, 2, 1'b0, 16'h0000);
    feed({CMD_ZERO, 5'd1});
    send_beat(1'b0, 8'h33);          // refused while the fill is pending
    settle();
    send_beat(1'b1, 8'h00);          // drain with nothing pending
    emit_cmd(CMD_REPEAT, 1, 1'b0, 16'h00A5);
    emit_cmd(CMD_COPY8, 2, 1'b0, 16'h0001);   // back offset of one
    emit_cmd(CMD_COPY16, 1, 1'b0, 16'hF000);  // offset wraps to zero
    emit_cmd(CMD_LITZ, 1, 1'b0, 16'h0000);
    emit_cmd(CMD_LIT, 0, 1'b1, 16'h0000);     // zero count, ends at once
    emit_cmd(CMD_COPY8, 0, 1'b1, 16'h0010);   // zero count still takes operand
    emit_cmd(CMD_BAD_HI, 2, 1'b1, 16'h0000);
    emit_cmd(CMD_BAD_LO, 5, 1'b0, 16'h0000);
    feed(END_MARKER);
    emit_cmd(CMD_LIT, 1, 1'b1, 16'h0000);

    // hold the sender until everything is out
    wait_drained();

    // Random: mostly well-formed commands, some junk and truncated ones.
    noisy = 1'b1;
    base  = fed_items;
    while (fed_items - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 29) == 0) quiet = !quiet;
      ext = ($urandom_range(0, 3) == 0);
      if (ext) cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 300)
                                                 : $urandom_range(0, 40);
      else cnt = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 31 : 6);
      opnd = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 300))
                                         : 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 8) begin
        broken_seq();
      end else if (r < 11) begin
        feed(END_MARKER);
      end else if (r < 16) begin
        c = ($urandom_range(0, 1) == 0) ? CMD_BAD_LO : CMD_BAD_HI;
        emit_cmd(c, cnt, ext, opnd);
      end else begin
        c = 3'($urandom_range(CMD_LIT, CMD_LITZ));
        emit_cmd(c, cnt, ext, opnd);
      end
    end

    // Back to back run from the far end of the window.
    quiet = 1'b1;
    noisy = 1'b0;
    emit_cmd(CMD_COPY16, 40, 1'b1, 16'hFFFF);
    quiet = 1'b0;
    emit_cmd(CMD_COPY8, 4, 1'b0, 16'h0003);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
